>>> sv/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared sizes and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_BITS = 3;
  localparam int RANK_BITS  = 3;
  localparam int CNT_BITS   = 16;
  localparam int CFG_BITS   = 4;
  localparam int ACT_BITS   = $clog2(FRAMES + 1);

  localparam logic [RANK_BITS-1:0] RANK_OLDEST = RANK_BITS'(FRAMES - 1);
  localparam logic [CNT_BITS-1:0]  CNT_MAX     = {CNT_BITS{1'b1}};

  typedef logic [FRAMES-1:0][PAGE_BITS-1:0] page_arr_t;
  typedef logic [FRAMES-1:0][RANK_BITS-1:0] rank_arr_t;

  // Lookup decision for one request.
  typedef struct packed {
    logic                  hit;
    logic                  evict;
    logic [FRAME_BITS-1:0] frame;
  } lpr_sel_t;

endpackage

>>> sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page frame tracker, one result per page request.
// ----------------------------------------------------------------------------
// Each request carries a page number and returns one result: hit or fault,
// the frame that holds the page afterwards, the evicted page if any, and a
// saturating fault count. A request is taken every cycle while the result
// side keeps up. A request sits in the input register while tag compare,
// victim choice and rank update run, and its result is loaded into the
// result register when the result side advances. A stalled result holds the
// input register, and the input stalls with it.
// cfg_wdata sets how many low frames take part (0 acts as 1, above 8 as 8);
// write it only while no request is in flight.
module lru_page_replacement import lpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [FRAME_BITS-1:0] out_frame_index,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic [CNT_BITS-1:0]   out_fault_count
);

  logic [CFG_BITS-1:0]   cfg_r;
  logic                  req_vld_r;
  logic [PAGE_BITS-1:0]  req_page_r;
  logic                  out_vld_r;
  logic                  hit_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic                  evict_r;
  logic [PAGE_BITS-1:0]  evict_page_r;
  logic [CNT_BITS-1:0]   fault_cnt_r;

  logic                  advance;
  logic                  fire;
  lpr_sel_t              sel;
  page_arr_t             frame_page;
  logic [FRAMES-1:0]     frame_valid;
  rank_arr_t             frame_rank;
  logic [PAGE_BITS-1:0]  evict_page;
  logic [CNT_BITS-1:0]   fault_nxt;

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = req_vld_r && advance;
  assign in_stall = req_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_BITS'(FRAMES);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= req_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_page_r <= in_page_number;
    end
    if (fire) begin
      hit_r        <= sel.hit;
      frame_r      <= sel.frame;
      evict_r      <= sel.evict;
      evict_page_r <= evict_page;
      fault_cnt_r  <= fault_nxt;
    end
  end

  lpr_lookup u_lookup (
    .frames_in_use (cfg_r),
    .page          (req_page_r),
    .frame_page    (frame_page),
    .frame_valid   (frame_valid),
    .frame_rank    (frame_rank),
    .sel           (sel)
  );

  lpr_frames u_frames (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (fire),
    .page        (req_page_r),
    .sel         (sel),
    .frame_page  (frame_page),
    .frame_valid (frame_valid),
    .frame_rank  (frame_rank),
    .evict_page  (evict_page),
    .fault_nxt   (fault_nxt)
  );

  assign out_valid         = out_vld_r;
  assign out_hit           = hit_r;
  assign out_frame_index   = frame_r;
  assign out_evicted_valid = evict_r;
  assign out_evicted_page  = evict_page_r;
  assign out_fault_count   = fault_cnt_r;

endmodule

>>> sv/lpr_lookup.sv
// ----------------------------------------------------------------------------
// lpr_lookup
// Tag compare, free frame search and victim choice over the active frames.
// ----------------------------------------------------------------------------
module lpr_lookup import lpr_pkg::*; (
  input  logic [CFG_BITS-1:0]  frames_in_use,
  input  logic [PAGE_BITS-1:0] page,
  input  page_arr_t            frame_page,
  input  logic [FRAMES-1:0]    frame_valid,
  input  rank_arr_t            frame_rank,
  output lpr_sel_t             sel
);

  logic [ACT_BITS-1:0]   act_cnt;
  logic                  hit_found;
  logic [FRAME_BITS-1:0] hit_frame;
  logic                  free_found;
  logic [FRAME_BITS-1:0] free_frame;
  logic [RANK_BITS-1:0]  best_rank;
  logic [FRAME_BITS-1:0] victim;

  always_comb begin
    if (frames_in_use == '0) begin
      act_cnt = ACT_BITS'(1);
    end else if (ACT_BITS'(frames_in_use) > ACT_BITS'(FRAMES)) begin
      act_cnt = ACT_BITS'(FRAMES);
    end else begin
      act_cnt = ACT_BITS'(frames_in_use);
    end
  end

  // Lowest index wins for hit and free search; strict compare keeps ties low.
  always_comb begin
    hit_found  = 1'b0;
    hit_frame  = '0;
    free_found = 1'b0;
    free_frame = '0;
    best_rank  = '0;
    victim     = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (ACT_BITS'(i) < act_cnt) begin
        if (!hit_found && frame_valid[i] && frame_page[i] == page) begin
          hit_found = 1'b1;
          hit_frame = FRAME_BITS'(i);
        end
        if (!free_found && !frame_valid[i]) begin
          free_found = 1'b1;
          free_frame = FRAME_BITS'(i);
        end
        if (frame_rank[i] > best_rank) begin
          best_rank = frame_rank[i];
          victim    = FRAME_BITS'(i);
        end
      end
    end
  end

  always_comb begin
    sel.hit   = hit_found;
    sel.evict = !hit_found && !free_found;
    if (hit_found) begin
      sel.frame = hit_frame;
    end else if (free_found) begin
      sel.frame = free_frame;
    end else begin
      sel.frame = victim;
    end
  end

endmodule

>>> sv/lpr_frames.sv
// ----------------------------------------------------------------------------
// lpr_frames
// Frame tags, valid bits, recency ranks and the fault counter.
// ----------------------------------------------------------------------------
module lpr_frames import lpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  logic [PAGE_BITS-1:0] page,
  input  lpr_sel_t             sel,
  output page_arr_t            frame_page,
  output logic [FRAMES-1:0]    frame_valid,
  output rank_arr_t            frame_rank,
  output logic [PAGE_BITS-1:0] evict_page,
  output logic [CNT_BITS-1:0]  fault_nxt
);

  page_arr_t            page_r;
  logic [FRAMES-1:0]    valid_r;
  logic [FRAMES-1:0]    valid_nxt;
  rank_arr_t            rank_r;
  rank_arr_t            rank_nxt;
  logic [CNT_BITS-1:0]  fault_r;
  logic [RANK_BITS-1:0] sel_rank;
  logic                 age_all;

  assign frame_page  = page_r;
  assign frame_valid = valid_r;
  assign frame_rank  = rank_r;
  assign sel_rank    = rank_r[sel.frame];
  // A fill into a free frame ages every valid frame.
  assign age_all     = !sel.hit && !sel.evict;
  assign evict_page  = sel.evict ? page_r[sel.frame] : '0;

  always_comb begin
    if (!sel.hit && fault_r != CNT_MAX) begin
      fault_nxt = fault_r + CNT_BITS'(1);
    end else begin
      fault_nxt = fault_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    for (int i = 0; i < FRAMES; i++) begin
      if (FRAME_BITS'(i) != sel.frame && valid_r[i] &&
          (age_all || rank_r[i] < sel_rank) && rank_r[i] != RANK_OLDEST) begin
        rank_nxt[i] = rank_r[i] + RANK_BITS'(1);
      end
    end
    rank_nxt[sel.frame]  = '0;
    valid_nxt[sel.frame] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
      fault_r <= '0;
    end else if (upd) begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && !sel.hit) begin
      page_r[sel.frame] <= page;
    end
  end

endmodule
